>>> hdl/srpg_pkg.sv
`timescale 1ns / 1ps

package srpg_pkg;

	// Operation codes carried in tuser.
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_MOVE_AB = 3'd1;
	localparam logic [2:0] OP_MOVE_RL = 3'd2;
	localparam logic [2:0] OP_SET_POS = 3'd3;
	localparam logic [2:0] OP_STOP    = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] CFG_INIT_INTERVAL = 3'd0;
	localparam logic [2:0] CFG_MIN_INTERVAL  = 3'd1;
	localparam logic [2:0] CFG_ACCELERATION  = 3'd2;
	localparam logic [2:0] CFG_LOW_POSITION  = 3'd3;
	localparam logic [2:0] CFG_HIGH_POSITION = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [31:0] RST_INIT_INTERVAL = 32'd244738048;
	localparam logic [31:0] RST_MIN_INTERVAL  = 32'd8533333;
	localparam logic [23:0] RST_ACCELERATION  = 24'd1;

	localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] POS_MIN = 32'sh80000000;

	// (1e6 * 256)^2: squared speed numerator for a Q24.8 interval.
	localparam logic [55:0] STOP_K = 56'hE8D4A510000000;

	// Divider geometry.
	localparam int DVD_W = 56;
	localparam int DVS_W = 33;

	// Datapath actions.
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_TICK,
		ACT_SETPOS,
		ACT_CAND_ABS,
		ACT_CAND_REL,
		ACT_CAND_STOP,
		ACT_CLAMP,
		ACT_SD_TRIV,
		ACT_SD_SAT,
		ACT_RC_IDX,
		ACT_RC_INIT,
		ACT_RC_APPLY,
		ACT_OUT_LOAD
	} dp_act_t;

	// Divider operand selection.
	typedef enum logic [1:0] {
		DIV_K_C,
		DIV_Q_C,
		DIV_Q_2A,
		DIV_RAMP
	} div_sel_t;

	typedef struct packed {
		dp_act_t  act;
		logic     div_start;
		div_sel_t div_sel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       tick_due;
		logic       clamp_changed;
		logic       sd_trivial;
		logic       rc_stop;
		logic       idx_zero;
		logic       in_motion;
		logic       div_busy;
		logic       out_free;
	} status_t;

	// Saturate a 33-bit signed sum to 32 bits.
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? POS_MIN : POS_MAX;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/stepper_ramp_profile_generator_top.sv
`timescale 1ns / 1ps

// Channel   Signals                          Contents (lowest bit up)
// s (in)    s_tvalid s_tready s_tdata s_tuser  tdata: position_value, encoder_position
//                                            tuser: operation
// m (out)   m_tvalid m_tready m_tdata          tdata: step_pulse, step_direction,
//                                            step_interval, running, distance_to_go
// cfg       cfg_we cfg_index cfg_data          register write, no read-back
//
// A tick that issues no step, a set-position and an idle stop go from decode straight to
// the finish state; a move that leaves the target unchanged passes the clamp state as well.
// A recompute runs up to four 56-step divisions on the shared one-bit-per-cycle divider, and
// a stop runs the stop-distance divisions twice. One item is worked on at a time; the next
// is accepted once the result sits in the output register, so a held output adds its stall
// to the item. Reset is asynchronous, active low, and needs no clearing pass.
module stepper_ramp_profile_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // position_value[31:0], encoder_position[63:32]
	input  logic [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // step_pulse[0], step_direction[1], step_interval[25:2],
	                               // running[26], distance_to_go[58:27], zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	srpg_pkg::cmd_t    cmd;
	srpg_pkg::status_t status;

	srpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	srpg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> hdl/srpg_div.sv
`timescale 1ns / 1ps

module srpg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [srpg_pkg::DVD_W-1:0]    dividend,
	input  logic [srpg_pkg::DVS_W-1:0]    divisor,
	output logic                          busy,
	output logic [srpg_pkg::DVD_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(srpg_pkg::DVD_W);

	logic [srpg_pkg::DVD_W-1:0] quo_q;
	logic [srpg_pkg::DVS_W-1:0] rem_q;
	logic [srpg_pkg::DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic [srpg_pkg::DVS_W:0]   shifted;
	logic [srpg_pkg::DVS_W+1:0] diff;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign shifted = {rem_q, quo_q[srpg_pkg::DVD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	// Control: count the steps of one division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(srpg_pkg::DVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Operands and partial results.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[srpg_pkg::DVS_W+1]) begin
				rem_q <= diff[srpg_pkg::DVS_W-1:0];
				quo_q <= {quo_q[srpg_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[srpg_pkg::DVS_W-1:0];
				quo_q <= {quo_q[srpg_pkg::DVD_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

>>> hdl/srpg_dp.sv
`timescale 1ns / 1ps

module srpg_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  srpg_pkg::cmd_t      cmd,
	output srpg_pkg::status_t   status,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [63:0]         s_tdata,
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [63:0]         m_tdata
);

	logic [31:0]        init_q, min_q;
	logic [23:0]        acc_q;
	logic signed [31:0] low_q, high_q;

	logic signed [31:0] target_q, current_q, idx_q;
	logic [31:0]        ramp_q, elapsed_q;
	logic [23:0]        issued_q;
	logic               cw_q, motion_q;

	logic [2:0]         op_q;
	logic signed [31:0] pv_q, enc_q, cand_q;
	logic [31:0]        sts_q;
	logic               pulse_q, pdir_q;
	logic               out_valid_q;
	logic [63:0]        out_data_q;

	logic                              div_busy;
	logic [srpg_pkg::DVD_W-1:0]        div_quo;
	logic [srpg_pkg::DVD_W-1:0]        div_dvd;
	logic [srpg_pkg::DVS_W-1:0]        div_dvs;

	logic signed [31:0] to_go, clamped, rel_sum, stop_cand, stop_off;
	logic [31:0]        abs_dist, e_inc, s_plus, c_new, c_lim;
	logic               want_cw, tick_due;
	logic [23:0]        a_eff;
	logic signed [34:0] d35, d_abs;
	logic [33:0]        c_sum;
	logic signed [31:0] idx_inc;

	// Distance to go, saturated, and its magnitude.
	assign to_go    = srpg_pkg::sat33({target_q[31], target_q} - {current_q[31], current_q});
	assign abs_dist = to_go[31] ? (~to_go + 32'd1) : to_go;
	assign want_cw  = !to_go[31] && (to_go != 32'sd0);

	// Tick: saturating counter and step due test.
	assign e_inc    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign tick_due = (issued_q != '0) && (e_inc >= {8'd0, issued_q});

	// Candidate targets and the position clamp.
	assign rel_sum   = srpg_pkg::sat33({current_q[31], current_q} + {pv_q[31], pv_q});
	assign s_plus    = (sts_q == 32'h7FFFFFFF) ? sts_q : sts_q + 32'd1;
	assign stop_off  = cw_q ? $signed(s_plus) : -$signed(s_plus);
	assign stop_cand = srpg_pkg::sat33({current_q[31], current_q} + {stop_off[31], stop_off});
	assign clamped   = (cand_q < low_q) ? low_q : ((cand_q < high_q) ? cand_q : high_q);

	// Divider operands.
	assign a_eff = (acc_q == '0) ? 24'd1 : acc_q;
	assign d35   = {idx_q[31], idx_q, 2'b01};
	assign d_abs = idx_q[31] ? -d35 : d35;

	always_comb begin
		unique case (cmd.div_sel)
			srpg_pkg::DIV_K_C: begin
				div_dvd = srpg_pkg::STOP_K;
				div_dvs = {1'b0, ramp_q};
			end
			srpg_pkg::DIV_Q_C: begin
				div_dvd = div_quo;
				div_dvs = {1'b0, ramp_q};
			end
			srpg_pkg::DIV_Q_2A: begin
				div_dvd = div_quo;
				div_dvs = {8'd0, a_eff, 1'b0};
			end
			default: begin
				div_dvd = {23'd0, ramp_q, 1'b0};
				div_dvs = d_abs[srpg_pkg::DVS_W-1:0];
			end
		endcase
	end

	srpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Next interval from the quotient: step down while accelerating, up while braking.
	always_comb begin
		if (!idx_q[31]) begin
			c_sum = {2'b00, ramp_q} - {1'b0, div_quo[32:0]};
		end else begin
			c_sum = {2'b00, ramp_q} + {1'b0, div_quo[32:0]};
		end
		c_new = (c_sum[33:32] != 2'b00) ? 32'hFFFFFFFF : c_sum[31:0];
		c_lim = (c_new < min_q) ? min_q : c_new;
	end

	assign idx_inc = (idx_q == srpg_pkg::POS_MAX) ? idx_q : idx_q + 32'sd1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= srpg_pkg::RST_INIT_INTERVAL;
			min_q  <= srpg_pkg::RST_MIN_INTERVAL;
			acc_q  <= srpg_pkg::RST_ACCELERATION;
			low_q  <= srpg_pkg::POS_MIN;
			high_q <= srpg_pkg::POS_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srpg_pkg::CFG_INIT_INTERVAL: init_q <= cfg_data;
				srpg_pkg::CFG_MIN_INTERVAL:  min_q  <= cfg_data;
				srpg_pkg::CFG_ACCELERATION:  acc_q  <= cfg_data[23:0];
				srpg_pkg::CFG_LOW_POSITION:  low_q  <= cfg_data;
				srpg_pkg::CFG_HIGH_POSITION: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Motion state, updated by the controller's actions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			current_q <= '0;
			idx_q     <= '0;
			ramp_q    <= '0;
			issued_q  <= '0;
			cw_q      <= 1'b0;
			elapsed_q <= '0;
			motion_q  <= 1'b0;
			pulse_q   <= 1'b0;
			pdir_q    <= 1'b0;
		end else begin
			case (cmd.act)
				srpg_pkg::ACT_LOAD: begin
					pulse_q <= 1'b0;
				end
				srpg_pkg::ACT_TICK: begin
					if (tick_due) begin
						pulse_q   <= 1'b1;
						pdir_q    <= cw_q;
						current_q <= enc_q;
						elapsed_q <= '0;
					end else begin
						elapsed_q <= e_inc;
					end
				end
				srpg_pkg::ACT_SETPOS: begin
					target_q  <= pv_q;
					current_q <= pv_q;
					idx_q     <= '0;
					issued_q  <= '0;
					motion_q  <= 1'b0;
				end
				srpg_pkg::ACT_CLAMP: begin
					target_q <= clamped;
				end
				srpg_pkg::ACT_RC_IDX: begin
					if (to_go == 32'sd0 && sts_q <= 32'd1) begin
						issued_q <= '0;
						motion_q <= 1'b0;
						idx_q    <= '0;
					end else if (to_go != 32'sd0) begin
						if (idx_q > 32'sd0) begin
							if (sts_q >= abs_dist || cw_q != want_cw) begin
								idx_q <= -$signed(sts_q);
							end
						end else if (idx_q < 32'sd0) begin
							if (sts_q < abs_dist && cw_q == want_cw) begin
								idx_q <= (idx_q == srpg_pkg::POS_MIN) ?
									srpg_pkg::POS_MAX : -idx_q;
							end
						end
					end
				end
				srpg_pkg::ACT_RC_INIT: begin
					ramp_q   <= init_q;
					cw_q     <= want_cw;
					idx_q    <= idx_inc;
					issued_q <= init_q[31:8];
					motion_q <= 1'b1;
				end
				srpg_pkg::ACT_RC_APPLY: begin
					ramp_q   <= c_lim;
					idx_q    <= idx_inc;
					issued_q <= c_lim[31:8];
					motion_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Item operands, candidate target and stop distance.
	always_ff @(posedge clk) begin
		case (cmd.act)
			srpg_pkg::ACT_LOAD: begin
				op_q  <= s_tuser;
				pv_q  <= s_tdata[31:0];
				enc_q <= s_tdata[63:32];
			end
			srpg_pkg::ACT_CAND_ABS:  cand_q <= pv_q;
			srpg_pkg::ACT_CAND_REL:  cand_q <= rel_sum;
			srpg_pkg::ACT_CAND_STOP: cand_q <= stop_cand;
			srpg_pkg::ACT_SD_TRIV:   sts_q  <= motion_q ? 32'h7FFFFFFF : 32'd0;
			srpg_pkg::ACT_SD_SAT: begin
				sts_q <= (div_quo[srpg_pkg::DVD_W-1:31] != '0) ? 32'h7FFFFFFF :
					{1'b0, div_quo[30:0]};
			end
			default: ;
		endcase
	end

	// Output register: holds one result transaction until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.act == srpg_pkg::ACT_OUT_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.act == srpg_pkg::ACT_OUT_LOAD) begin
			out_data_q <= {5'd0, to_go,
				(motion_q || target_q != current_q),
				issued_q,
				(pulse_q ? pdir_q : cw_q),
				pulse_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Status back to the controller.
	always_comb begin
		status.op            = op_q;
		status.tick_due      = tick_due;
		status.clamp_changed = (target_q != clamped);
		status.sd_trivial    = !motion_q || (ramp_q == '0);
		status.rc_stop       = (to_go == 32'sd0) && (sts_q <= 32'd1);
		status.idx_zero      = (idx_q == 32'sd0);
		status.in_motion     = motion_q;
		status.div_busy      = div_busy;
		status.out_free      = !out_valid_q || m_tready;
	end

`ifndef ASSERT_OFF
	// While moving, the issued interval is always the whole part of the ramp interval.
	a_issued_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		motion_q |-> (issued_q == ramp_q[31:8]))
		else $error("issued interval out of step with ramp interval");
`endif

endmodule

>>> hdl/srpg_ctrl.sv
`timescale 1ns / 1ps

module srpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  srpg_pkg::status_t   status,
	output srpg_pkg::cmd_t      cmd
);

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b000000000001,
		ST_DECODE  = 12'b000000000010,
		ST_CLAMP   = 12'b000000000100,
		ST_STOPADD = 12'b000000001000,
		ST_SD_CHK  = 12'b000000010000,
		ST_SD1W    = 12'b000000100000,
		ST_SD2W    = 12'b000001000000,
		ST_SD3W    = 12'b000010000000,
		ST_RC_IDX  = 12'b000100000000,
		ST_RC_INT  = 12'b001000000000,
		ST_RC_WAIT = 12'b010000000000,
		ST_FINISH  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   stop_q, stop_d;

	// Next state and datapath command.
	always_comb begin
		state_d       = state_q;
		stop_d        = stop_q;
		cmd.act       = srpg_pkg::ACT_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = srpg_pkg::DIV_K_C;
		s_tready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.act = srpg_pkg::ACT_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				stop_d = 1'b0;
				unique case (status.op)
					srpg_pkg::OP_TICK: begin
						cmd.act = srpg_pkg::ACT_TICK;
						state_d = status.tick_due ? ST_SD_CHK : ST_FINISH;
					end
					srpg_pkg::OP_MOVE_AB: begin
						cmd.act = srpg_pkg::ACT_CAND_ABS;
						state_d = ST_CLAMP;
					end
					srpg_pkg::OP_MOVE_RL: begin
						cmd.act = srpg_pkg::ACT_CAND_REL;
						state_d = ST_CLAMP;
					end
					srpg_pkg::OP_SET_POS: begin
						cmd.act = srpg_pkg::ACT_SETPOS;
						state_d = ST_FINISH;
					end
					srpg_pkg::OP_STOP: begin
						if (status.in_motion) begin
							stop_d  = 1'b1;
							state_d = ST_SD_CHK;
						end else begin
							state_d = ST_FINISH;
						end
					end
					default: state_d = ST_FINISH;
				endcase
			end
			ST_STOPADD: begin
				cmd.act = srpg_pkg::ACT_CAND_STOP;
				stop_d  = 1'b0;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.act = srpg_pkg::ACT_CLAMP;
				state_d = status.clamp_changed ? ST_SD_CHK : ST_FINISH;
			end
			ST_SD_CHK: begin
				if (status.sd_trivial) begin
					cmd.act = srpg_pkg::ACT_SD_TRIV;
					state_d = stop_q ? ST_STOPADD : ST_RC_IDX;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = srpg_pkg::DIV_K_C;
					state_d       = ST_SD1W;
				end
			end
			ST_SD1W: begin
				if (!status.div_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = srpg_pkg::DIV_Q_C;
					state_d       = ST_SD2W;
				end
			end
			ST_SD2W: begin
				if (!status.div_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = srpg_pkg::DIV_Q_2A;
					state_d       = ST_SD3W;
				end
			end
			ST_SD3W: begin
				if (!status.div_busy) begin
					cmd.act = srpg_pkg::ACT_SD_SAT;
					state_d = stop_q ? ST_STOPADD : ST_RC_IDX;
				end
			end
			ST_RC_IDX: begin
				cmd.act = srpg_pkg::ACT_RC_IDX;
				state_d = status.rc_stop ? ST_FINISH : ST_RC_INT;
			end
			ST_RC_INT: begin
				if (status.idx_zero) begin
					cmd.act = srpg_pkg::ACT_RC_INIT;
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = srpg_pkg::DIV_RAMP;
					state_d       = ST_RC_WAIT;
				end
			end
			ST_RC_WAIT: begin
				cmd.div_sel = srpg_pkg::DIV_RAMP;
				if (!status.div_busy) begin
					cmd.act = srpg_pkg::ACT_RC_APPLY;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.act = srpg_pkg::ACT_OUT_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			stop_q  <= stop_d;
		end
	end

`ifndef ASSERT_OFF
	// The shared divider is never restarted mid-division.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider started while busy");

	// A result is only written into a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == srpg_pkg::ACT_OUT_LOAD) |-> status.out_free)
		else $error("result written over a pending transaction");

	// Every accepted item leads to the decode state next.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DECODE))
		else $error("accepted item not decoded");
`endif

endmodule

>>> tb/tb_stepper_ramp_profile_generator_top.sv
`timescale 1ns / 1ps

module tb_stepper_ramp_profile_generator_top;

	localparam longint P_MAX = 64'sd2147483647;
	localparam longint P_MIN = -64'sd2147483648;
	localparam longint unsigned SPEED_SQ = 64'd65536000000000000;

	// One command as offered on the input stream.
	typedef struct {
		logic [2:0]  op;
		logic [31:0] pos;
		logic [31:0] enc;
		bit          follow;
	} cmd_item_t;

	// One status word as carried on the output stream.
	typedef struct packed {
		logic        pulse;
		logic        dir;
		logic [23:0] interval;
		logic        running;
		logic [31:0] togo;
	} status_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	stepper_ramp_profile_generator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cmd_item_t    pending_cmds[$];
	status_word_t expected_status[$];

	int  n_accepted = 0;
	int  n_results = 0;
	int  n_steps = 0;
	int  n_errors = 0;
	int  hold_left = 0;
	bit  held_once = 1'b0;
	bit  took = 1'b0;

	// Motion model: limits and ramp settings, then the motion state.
	longint unsigned c_first, c_floor;
	longint unsigned accel;
	longint lim_lo, lim_hi;
	longint tgt_pos, cur_pos, ramp_n;
	longint unsigned ramp_c;
	logic [23:0] step_us;
	bit     cw;
	longint unsigned ticks;
	bit     moving;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint sat32(input longint v);
		if (v > P_MAX) return P_MAX;
		if (v < P_MIN) return P_MIN;
		return v;
	endfunction

	function automatic longint braking_steps();
		longint unsigned q, a;
		a = (accel == 0) ? 1 : accel;
		if (!moving) return 0;
		if (ramp_c == 0) return P_MAX;
		q = SPEED_SQ / ramp_c;
		q = q / ramp_c;
		q = q / (2 * a);
		return (q > P_MAX) ? P_MAX : longint'(q);
	endfunction

	// Next interval of the ramp after a step or a target change.
	function automatic void update_ramp();
		longint to_go, brake, ad, d;
		longint unsigned ud, c, q;
		bit want_cw;
		to_go = sat32(tgt_pos - cur_pos);
		brake = braking_steps();
		if (to_go == 0 && brake <= 1) begin
			step_us = 0;
			moving = 0;
			ramp_n = 0;
			return;
		end
		if (to_go != 0) begin
			ad = (to_go > 0) ? to_go : -to_go;
			want_cw = to_go > 0;
			if (ramp_n > 0) begin
				if (brake >= ad || cw != want_cw) ramp_n = -brake;
			end else if (ramp_n < 0) begin
				if (brake < ad && cw == want_cw) ramp_n = sat32(-ramp_n);
			end
		end
		if (ramp_n == 0) begin
			ramp_c = c_first;
			cw = to_go > 0;
		end else begin
			d = 4 * ramp_n + 1;
			ud = (d < 0) ? -d : d;
			c = ramp_c;
			q = (2 * c) / ud;
			if (d > 0) c = c - q;
			else c = c + q;
			if (c > 64'hFFFFFFFF) c = 64'hFFFFFFFF;
			if (c < c_floor) c = c_floor;
			ramp_c = c;
		end
		if (ramp_n < P_MAX) ramp_n++;
		step_us = ramp_c[31:8];
		moving = 1;
	endfunction

	function automatic void aim_at(input longint p);
		p = (p < lim_lo) ? lim_lo : ((p < lim_hi) ? p : lim_hi);
		if (tgt_pos != p) begin
			tgt_pos = p;
			update_ramp();
		end
	endfunction

	function automatic status_word_t apply_command(input cmd_item_t it);
		status_word_t r;
		longint s;
		bit pulse, dir;
		pulse = 0;
		dir = 0;
		case (it.op)
			srpg_pkg::OP_TICK: begin
				if (ticks != 64'hFFFFFFFF) ticks++;
				if (step_us != 0 && ticks >= step_us) begin
					pulse = 1;
					dir = cw;
					cur_pos = longint'(signed'(it.enc));
					ticks = 0;
					update_ramp();
				end
			end
			srpg_pkg::OP_MOVE_AB: aim_at(longint'(signed'(it.pos)));
			srpg_pkg::OP_MOVE_RL: aim_at(sat32(cur_pos + longint'(signed'(it.pos))));
			srpg_pkg::OP_SET_POS: begin
				tgt_pos = longint'(signed'(it.pos));
				cur_pos = tgt_pos;
				ramp_n = 0;
				step_us = 0;
				moving = 0;
			end
			srpg_pkg::OP_STOP: begin
				if (moving) begin
					s = braking_steps();
					if (s < P_MAX) s++;
					aim_at(sat32(cur_pos + (cw ? s : -s)));
				end
			end
			default: ;
		endcase
		if (!pulse) dir = cw;
		r.pulse = pulse;
		r.dir = dir;
		r.interval = step_us;
		r.running = moving || (tgt_pos != cur_pos);
		r.togo = 32'(sat32(tgt_pos - cur_pos));
		return r;
	endfunction

	// Input side: a transaction is taken at the rising edge and predicted at once.
	always @(posedge clk) begin
		took <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			cmd_item_t it;
			status_word_t e;
			it.op = s_tuser;
			it.pos = s_tdata[31:0];
			it.enc = s_tdata[63:32];
			it.follow = 0;
			e = apply_command(it);
			if (e.pulse) n_steps++;
			expected_status.push_back(e);
			n_accepted++;
		end
	end

	// Driver: offers the next pending command, idling now and then.
	always @(negedge clk) begin
		cmd_item_t it;
		bit calm, gap;
		calm = (n_accepted >= 150 && n_accepted < 300);
		gap = !calm && ($urandom_range(99) < 10);
		if (!s_tvalid || took) begin
			if (pending_cmds.size() > 0 && !gap && arst_n) begin
				it = pending_cmds.pop_front();
				if (it.follow) it.enc = 32'(cur_pos + (cw ? 1 : -1));
				s_tuser <= it.op;
				s_tdata <= {it.enc, it.pos};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver readiness, with one long hold-off to back the block up.
	always @(negedge clk) begin
		bit calm;
		calm = (n_results >= 150 && n_results < 300);
		if (!held_once && n_results == 400) begin
			held_once <= 1'b1;
			hold_left <= 300;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && (calm || $urandom_range(99) >= 10);
		end
	end

	// Monitor: each output transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		status_word_t got, want;
		if (m_tvalid && m_tready) begin
			got.pulse = m_tdata[0];
			got.dir = m_tdata[1];
			got.interval = m_tdata[25:2];
			got.running = m_tdata[26];
			got.togo = m_tdata[58:27];
			n_results++;
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected status word %h", $time, m_tdata);
				n_errors++;
			end else begin
				want = expected_status.pop_front();
				if (got.pulse !== want.pulse) begin
					$display("%0t: step_pulse expected %0d got %0d", $time, want.pulse,
						got.pulse);
					n_errors++;
				end
				if (got.dir !== want.dir) begin
					$display("%0t: step_direction expected %0d got %0d", $time, want.dir,
						got.dir);
					n_errors++;
				end
				if (got.interval !== want.interval) begin
					$display("%0t: step_interval expected %0d got %0d", $time,
						want.interval, got.interval);
					n_errors++;
				end
				if (got.running !== want.running) begin
					$display("%0t: running expected %0d got %0d", $time, want.running,
						got.running);
					n_errors++;
				end
				if (got.togo !== want.togo) begin
					$display("%0t: distance_to_go expected %0d got %0d", $time,
						$signed(want.togo), $signed(got.togo));
					n_errors++;
				end
			end
		end
	end

	task automatic queue_cmd(input logic [2:0] op, input logic [31:0] pos,
			input logic [31:0] enc, input bit follow);
		cmd_item_t it;
		it.op = op;
		it.pos = pos;
		it.enc = enc;
		it.follow = follow;
		pending_cmds.push_back(it);
	endtask

	// Wait for every transaction to complete, then for the longest recompute.
	task automatic drain();
		while (pending_cmds.size() > 0 || s_tvalid || expected_status.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			srpg_pkg::CFG_INIT_INTERVAL: c_first = val;
			srpg_pkg::CFG_MIN_INTERVAL: c_floor = val;
			srpg_pkg::CFG_ACCELERATION: accel = val[23:0];
			srpg_pkg::CFG_LOW_POSITION: lim_lo = longint'(signed'(val));
			srpg_pkg::CFG_HIGH_POSITION: lim_hi = longint'(signed'(val));
			default: ;
		endcase
	endtask

	// A move followed by ticks that report the position one step on, with some noise.
	task automatic queue_moves(input int n_items, input int reach);
		int k, r;
		k = 0;
		while (k < n_items) begin
			r = $urandom_range(99);
			if (r < 2) queue_cmd(3'($urandom_range(7, 5)), $urandom, $urandom, 0);
			else if (r < 6) queue_cmd(srpg_pkg::OP_STOP, $urandom, $urandom, 0);
			else if (r < 8) queue_cmd(srpg_pkg::OP_SET_POS,
				32'($signed($urandom_range(2 * reach)) - reach), $urandom, 0);
			else if (r < 14) queue_cmd(3'($urandom_range(4)), $urandom, $urandom, 0);
			else if (r < 30) queue_cmd(srpg_pkg::OP_MOVE_AB,
				32'($signed($urandom_range(2 * reach)) - reach), $urandom, 0);
			else queue_cmd(srpg_pkg::OP_MOVE_RL,
				32'($signed($urandom_range(2 * reach)) - reach), $urandom, 0);
			k++;
			repeat ($urandom_range(40, 5)) begin
				queue_cmd(srpg_pkg::OP_TICK, $urandom, $urandom, $urandom_range(99) < 92);
				k++;
			end
		end
	endtask

	initial begin
		c_first = srpg_pkg::RST_INIT_INTERVAL;
		c_floor = srpg_pkg::RST_MIN_INTERVAL;
		accel = srpg_pkg::RST_ACCELERATION;
		lim_lo = P_MIN;
		lim_hi = P_MAX;
		tgt_pos = 0;
		cur_pos = 0;
		ramp_n = 0;
		ramp_c = 0;
		step_us = 0;
		cw = 0;
		ticks = 0;
		moving = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every operation, unknown codes, field extremes and saturation.
		queue_cmd(srpg_pkg::OP_TICK, 32'h0, 32'h0, 0);
		queue_cmd(3'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		queue_cmd(3'd6, 32'h0, 32'h0, 0);
		queue_cmd(3'd7, 32'h12345678, 32'h87654321, 0);
		queue_cmd(srpg_pkg::OP_STOP, 32'h0, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_MOVE_AB, 32'h7FFFFFFF, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_TICK, 32'hFFFFFFFF, 32'h80000000, 0);
		queue_cmd(srpg_pkg::OP_STOP, 32'h0, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_SET_POS, 32'h80000000, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_MOVE_AB, 32'h7FFFFFFF, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_MOVE_AB, 32'h7FFFFFFF, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_MOVE_RL, 32'h80000000, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_SET_POS, 32'h7FFFFFFF, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_MOVE_RL, 32'h7FFFFFFF, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_MOVE_AB, 32'h80000000, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_SET_POS, 32'h0, 32'h0, 0);
		queue_cmd(srpg_pkg::OP_MOVE_RL, 32'hFFFFFFFF, 32'h0, 0);
		drain();

		// Short intervals and tight limits, so that the ramp runs through its phases.
		write_reg(srpg_pkg::CFG_INIT_INTERVAL, 32'd2560);
		write_reg(srpg_pkg::CFG_MIN_INTERVAL, 32'd256);
		write_reg(srpg_pkg::CFG_ACCELERATION, 32'h00FFFFFF);
		write_reg(srpg_pkg::CFG_LOW_POSITION, 32'($signed(-1000)));
		write_reg(srpg_pkg::CFG_HIGH_POSITION, 32'd1000);
		queue_moves(320, 60);
		repeat (20) queue_cmd(3'($urandom_range(7)), $urandom, $urandom, 0);
		drain();

		// Highest floor, weakest acceleration and inverted limits.
		write_reg(srpg_pkg::CFG_INIT_INTERVAL, 32'd1500);
		write_reg(srpg_pkg::CFG_MIN_INTERVAL, 32'hFFFFFFFF);
		write_reg(srpg_pkg::CFG_ACCELERATION, 32'd1);
		write_reg(srpg_pkg::CFG_LOW_POSITION, 32'd500);
		write_reg(srpg_pkg::CFG_HIGH_POSITION, 32'($signed(-500)));
		queue_cmd(srpg_pkg::OP_SET_POS, 32'd0, 32'd0, 0);
		queue_moves(60, 900);
		drain();

		// Zero and full initial interval.
		write_reg(srpg_pkg::CFG_INIT_INTERVAL, 32'd0);
		write_reg(srpg_pkg::CFG_MIN_INTERVAL, 32'd256);
		write_reg(srpg_pkg::CFG_LOW_POSITION, 32'h80000000);
		write_reg(srpg_pkg::CFG_HIGH_POSITION, 32'h7FFFFFFF);
		queue_cmd(srpg_pkg::OP_SET_POS, 32'd0, 32'd0, 0);
		queue_moves(20, 30);
		drain();
		write_reg(srpg_pkg::CFG_INIT_INTERVAL, 32'hFFFFFFFF);
		queue_moves(20, 30);
		drain();

		// Moderate ramp with full limits and wide random noise.
		write_reg(srpg_pkg::CFG_INIT_INTERVAL, 32'd5000);
		write_reg(srpg_pkg::CFG_MIN_INTERVAL, 32'd600);
		write_reg(srpg_pkg::CFG_ACCELERATION, 32'd1000000);
		queue_cmd(srpg_pkg::OP_SET_POS, 32'd0, 32'd0, 0);
		queue_moves(260, 200);
		repeat (30) queue_cmd(3'($urandom_range(7)), $urandom, $urandom, 0);
		drain();

		$display("Covered %0d commands with %0d steps and %0d status words checked,",
			n_accepted, n_steps, n_results);
		$display("over five register settings including the field extremes.");
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Run timed out.");
		$display("TEST FAILED");
		$finish;
	end

endmodule
